[src/tx_skeleton_stream_parser_defines.svh]
// Assertion macros used by the checker in tsp_checker.sv
`ifndef TX_SKELETON_STREAM_PARSER_DEFINES_SVH
`define TX_SKELETON_STREAM_PARSER_DEFINES_SVH

// Assert that a property holds on every clock edge outside reset
`define TSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assert a property that must also hold during reset
`define TSP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/tsp_pkg.sv]
`default_nettype none
package tsp_pkg;
   localparam int COUNT_LIMIT_DEF  = 1024;
   localparam int SCRIPT_LIMIT_DEF = 16383;

   localparam logic [10:0] MAX_INPUTS_RST  = 11'd1000;
   localparam logic [10:0] MAX_OUTPUTS_RST = 11'd1000;
   localparam logic [13:0] MAX_SCRIPT_RST  = 14'd10000;

   localparam logic [1:0] REG_MAX_INPUTS  = 2'd0;
   localparam logic [1:0] REG_MAX_OUTPUTS = 2'd1;
   localparam logic [1:0] REG_MAX_SCRIPT  = 2'd2;

   typedef enum logic [3:0] {
      KIND_VERSION    = 4'd0,
      KIND_IN_COUNT   = 4'd1,
      KIND_TXID       = 4'd2,
      KIND_VOUT       = 4'd3,
      KIND_SEQUENCE   = 4'd4,
      KIND_OUT_COUNT  = 4'd5,
      KIND_VALUE      = 4'd6,
      KIND_SCRIPT_LEN = 4'd7,
      KIND_SCRIPT     = 4'd8,
      KIND_LOCKTIME   = 4'd9,
      KIND_DONE       = 4'd10,
      KIND_ERROR      = 4'd11
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_TRUNC     = 3'd1,
      ERR_IN_COUNT  = 3'd2,
      ERR_SCRIPTSIG = 3'd3,
      ERR_OUT_COUNT = 3'd4,
      ERR_SCRIPT    = 3'd5,
      ERR_TAG8      = 3'd6,
      ERR_TRAILING  = 3'd7
   } err_type;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] value;
      logic [9:0]  index;
      logic [13:0] pos;
      err_type     code;
   } rec_type;

   // One parsed byte: up to two result records
   typedef struct packed {
      logic    has0;
      logic    has1;
      rec_type r0;
      rec_type r1;
   } entry_type;
endpackage
`default_nettype wire

[src/tsp_front.sv]
`default_nettype none
module tsp_front #(
   parameter int COUNT_LIMIT  = tsp_pkg::COUNT_LIMIT_DEF,
   parameter int SCRIPT_LIMIT = tsp_pkg::SCRIPT_LIMIT_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [7:0]         in_byte,
   input  wire logic               in_last,
   output logic                    in_ready,
   input  wire logic [10:0]        max_inputs,
   input  wire logic [10:0]        max_outputs,
   input  wire logic [13:0]        max_script_len,
   output logic                    q_push,
   output tsp_pkg::entry_type      q_data,
   input  wire logic               q_full
);
   localparam int CW = $clog2(COUNT_LIMIT + 1);
   localparam int SW = $clog2(SCRIPT_LIMIT + 1);
   localparam logic [10:0] CLIM = (COUNT_LIMIT > 2047) ? 11'h7ff : 11'(COUNT_LIMIT);
   localparam logic [13:0] SLIM = (SCRIPT_LIMIT > 16383) ? 14'h3fff : 14'(SCRIPT_LIMIT);

   typedef enum logic [3:0] {
      PH_VERSION, PH_IN_COUNT, PH_TXID, PH_VOUT, PH_SSIG, PH_SEQ, PH_OUT_COUNT,
      PH_VALUE, PH_SCRIPT_LEN, PH_SCRIPT, PH_LOCKTIME, PH_COMPLETE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;
   logic [2:0]  vw_ff, vw_in;
   logic [CW-1:0] left_ff, left_in;
   logic [9:0]  item_ff, item_in;
   logic [SW-1:0] sleft_ff, sleft_in;
   logic [13:0] soff_ff, soff_in;
   logic        err_ff, err_in;
   logic        done_ff, done_in;

   logic [10:0] lim_in_c, lim_out_c;
   logic [13:0] lim_s;
   logic        fx_done;
   logic [63:0] fx_val, acc_or;
   logic [3:0]  fx_width;
   logic [1:0]  vi_res;
   logic [63:0] vi_val;
   logic        accept;
   tsp_pkg::rec_type  rec;
   logic              has;
   tsp_pkg::entry_type ent;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;
   assign lim_in_c  = (max_inputs < CLIM) ? max_inputs : CLIM;
   assign lim_out_c = (max_outputs < CLIM) ? max_outputs : CLIM;
   assign lim_s     = (max_script_len < SLIM) ? max_script_len : SLIM;

   function automatic tsp_pkg::rec_type mk(tsp_pkg::kind_type k, logic [63:0] v,
                                           logic [9:0] i, logic [13:0] p,
                                           tsp_pkg::err_type c);
      tsp_pkg::rec_type r;
      r.kind = k; r.value = v; r.index = i; r.pos = p; r.code = c;
      return r;
   endfunction

   always_comb begin
      phase_in = phase_ff; cnt_in = cnt_ff; acc_in = acc_ff; vw_in = vw_ff;
      left_in = left_ff; item_in = item_ff; sleft_in = sleft_ff; soff_in = soff_ff;
      err_in = err_ff; done_in = done_ff;
      rec = mk(tsp_pkg::KIND_ERROR, 64'd0, 10'd0, 14'd0, tsp_pkg::ERR_NONE);
      has = 1'b0;
      ent = '0;

      fx_width = (phase_ff == PH_VALUE) ? 4'd8 : 4'd4;
      acc_or   = acc_ff | ({56'd0, in_byte} << {cnt_ff[2:0], 3'b000});
      fx_done  = ({1'b0, cnt_ff} + 6'd1) >= {2'b00, fx_width};
      fx_val   = acc_or;

      vi_res = 2'd0;
      vi_val = 64'd0;
      if (cnt_ff == 5'd0) begin
         if (in_byte < 8'hfd) begin
            vi_res = 2'd1; vi_val = {56'd0, in_byte};
         end else if (in_byte == 8'hff) begin
            vi_res = 2'd2;
         end
      end else begin
         vi_val = acc_ff | ({56'd0, in_byte} << {(cnt_ff[1:0] - 2'd1), 3'b000});
         if (cnt_ff >= {2'b00, vw_ff}) vi_res = 2'd1;
      end

      if (!err_ff) begin
         if (done_ff) begin
            has = 1'b1; err_in = 1'b1;
            rec = mk(tsp_pkg::KIND_ERROR, 64'd0, 10'd0, 14'd0, tsp_pkg::ERR_TRAILING);
         end else begin
            case (phase_ff)
               PH_VERSION, PH_VOUT, PH_SEQ, PH_VALUE, PH_LOCKTIME: begin
                  if (fx_done) begin
                     acc_in = 64'd0; cnt_in = 5'd0; has = 1'b1;
                     case (phase_ff)
                        PH_VERSION: begin
                           rec = mk(tsp_pkg::KIND_VERSION, fx_val, 10'd0, 14'd0,
                                    tsp_pkg::ERR_NONE);
                           phase_in = PH_IN_COUNT;
                        end
                        PH_VOUT: begin
                           rec = mk(tsp_pkg::KIND_VOUT, fx_val, item_ff, 14'd0,
                                    tsp_pkg::ERR_NONE);
                           phase_in = PH_SSIG;
                        end
                        PH_SEQ: begin
                           rec = mk(tsp_pkg::KIND_SEQUENCE, fx_val, item_ff, 14'd0,
                                    tsp_pkg::ERR_NONE);
                           left_in = left_ff - CW'(1);
                           item_in = item_ff + 10'd1;
                           phase_in = (left_ff == CW'(1)) ? PH_OUT_COUNT : PH_TXID;
                        end
                        PH_VALUE: begin
                           rec = mk(tsp_pkg::KIND_VALUE, fx_val, item_ff, 14'd0,
                                    tsp_pkg::ERR_NONE);
                           phase_in = PH_SCRIPT_LEN;
                        end
                        default: begin
                           rec = mk(tsp_pkg::KIND_LOCKTIME, fx_val, 10'd0, 14'd0,
                                    tsp_pkg::ERR_NONE);
                           done_in = 1'b1;
                           phase_in = PH_COMPLETE;
                        end
                     endcase
                  end else begin
                     acc_in = acc_or; cnt_in = cnt_ff + 5'd1;
                  end
               end
               PH_IN_COUNT, PH_OUT_COUNT, PH_SSIG, PH_SCRIPT_LEN: begin
                  if (cnt_ff == 5'd0) begin
                     acc_in = 64'd0;
                     if (vi_res == 2'd0) begin
                        vw_in = (in_byte == 8'hfd) ? 3'd2 : 3'd4;
                        cnt_in = 5'd1;
                     end
                  end else if (vi_res == 2'd0) begin
                     acc_in = vi_val; cnt_in = cnt_ff + 5'd1;
                  end else begin
                     acc_in = 64'd0; cnt_in = 5'd0; vw_in = 3'd0;
                  end
                  if (vi_res == 2'd2) begin
                     has = 1'b1; err_in = 1'b1;
                     rec = mk(tsp_pkg::KIND_ERROR, 64'd0, 10'd0, 14'd0, tsp_pkg::ERR_TAG8);
                  end else if (vi_res == 2'd1) begin
                     case (phase_ff)
                        PH_IN_COUNT, PH_OUT_COUNT: begin
                           has = 1'b1;
                           if (vi_val == 64'd0 || vi_val > {53'd0,
                               (phase_ff == PH_IN_COUNT) ? lim_in_c : lim_out_c}) begin
                              err_in = 1'b1;
                              rec = mk(tsp_pkg::KIND_ERROR, 64'd0, 10'd0, 14'd0,
                                       (phase_ff == PH_IN_COUNT) ? tsp_pkg::ERR_IN_COUNT
                                                                 : tsp_pkg::ERR_OUT_COUNT);
                           end else begin
                              rec = mk((phase_ff == PH_IN_COUNT) ? tsp_pkg::KIND_IN_COUNT
                                                                 : tsp_pkg::KIND_OUT_COUNT,
                                       vi_val, 10'd0, 14'd0, tsp_pkg::ERR_NONE);
                              left_in = vi_val[CW-1:0];
                              item_in = 10'd0;
                              phase_in = (phase_ff == PH_IN_COUNT) ? PH_TXID : PH_VALUE;
                           end
                        end
                        PH_SSIG: begin
                           if (vi_val != 64'd0) begin
                              has = 1'b1; err_in = 1'b1;
                              rec = mk(tsp_pkg::KIND_ERROR, 64'd0, 10'd0, 14'd0,
                                       tsp_pkg::ERR_SCRIPTSIG);
                           end else begin
                              phase_in = PH_SEQ;
                           end
                        end
                        default: begin
                           has = 1'b1;
                           if (vi_val > {50'd0, lim_s}) begin
                              err_in = 1'b1;
                              rec = mk(tsp_pkg::KIND_ERROR, 64'd0, 10'd0, 14'd0,
                                       tsp_pkg::ERR_SCRIPT);
                           end else begin
                              rec = mk(tsp_pkg::KIND_SCRIPT_LEN, vi_val, item_ff, 14'd0,
                                       tsp_pkg::ERR_NONE);
                              sleft_in = vi_val[SW-1:0];
                              soff_in = 14'd0;
                              if (vi_val == 64'd0) begin
                                 left_in = left_ff - CW'(1);
                                 item_in = item_ff + 10'd1;
                                 phase_in = (left_ff == CW'(1)) ? PH_LOCKTIME : PH_VALUE;
                              end else begin
                                 phase_in = PH_SCRIPT;
                              end
                           end
                        end
                     endcase
                  end
               end
               PH_TXID: begin
                  has = 1'b1;
                  rec = mk(tsp_pkg::KIND_TXID, {56'd0, in_byte}, item_ff,
                           {9'd0, 5'd31 - cnt_ff}, tsp_pkg::ERR_NONE);
                  if (cnt_ff >= 5'd31) begin
                     cnt_in = 5'd0; phase_in = PH_VOUT;
                  end else begin
                     cnt_in = cnt_ff + 5'd1;
                  end
               end
               PH_SCRIPT: begin
                  has = 1'b1;
                  rec = mk(tsp_pkg::KIND_SCRIPT, {56'd0, in_byte}, item_ff, soff_ff,
                           tsp_pkg::ERR_NONE);
                  soff_in = soff_ff + 14'd1;
                  sleft_in = sleft_ff - SW'(1);
                  if (sleft_ff == SW'(1)) begin
                     left_in = left_ff - CW'(1);
                     item_in = item_ff + 10'd1;
                     phase_in = (left_ff == CW'(1)) ? PH_LOCKTIME : PH_VALUE;
                  end
               end
               default: ;
            endcase
         end
      end

      ent.has0 = has;
      ent.r0   = rec;
      if (in_last) begin
         if (!err_in) begin
            ent.has1 = 1'b1;
            ent.r1 = mk(done_in ? tsp_pkg::KIND_DONE : tsp_pkg::KIND_ERROR, 64'd0, 10'd0,
                        14'd0, done_in ? tsp_pkg::ERR_NONE : tsp_pkg::ERR_TRUNC);
         end
         phase_in = PH_VERSION; cnt_in = 5'd0; acc_in = 64'd0; vw_in = 3'd0;
         left_in = '0; item_in = 10'd0; sleft_in = '0; soff_in = 14'd0;
         err_in = 1'b0; done_in = 1'b0;
      end
   end

   assign q_push = accept && (ent.has0 || ent.has1);
   assign q_data = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_VERSION; cnt_ff <= '0; acc_ff <= '0; vw_ff <= '0;
         left_ff <= '0; item_ff <= '0; sleft_ff <= '0; soff_ff <= '0;
         err_ff <= 1'b0; done_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in; cnt_ff <= cnt_in; acc_ff <= acc_in; vw_ff <= vw_in;
         left_ff <= left_in; item_ff <= item_in; sleft_ff <= sleft_in;
         soff_ff <= soff_in; err_ff <= err_in; done_ff <= done_in;
      end
   end
endmodule
`default_nettype wire

[src/tsp_fifo.sv]
`default_nettype none
module tsp_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tsp_pkg::entry_type push_data,
   output logic                    full,
   output logic                    not_empty,
   output tsp_pkg::entry_type      head,
   input  wire logic               pop
);
   tsp_pkg::entry_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   assign full      = (cnt_ff == 3'd4);
   assign not_empty = (cnt_ff != 3'd0);
   assign head      = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, push} - {2'd0, pop};
      end
   end
endmodule
`default_nettype wire

[src/tsp_back.sv]
`default_nettype none
module tsp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire tsp_pkg::entry_type q_head,
   output logic                    q_pop,
   output logic                    out_valid,
   output tsp_pkg::rec_type        out_rec,
   output logic                    out_end,
   input  wire logic               out_ready
);
   logic second_ff;
   logic both;

   assign both      = q_head.has0 && q_head.has1;
   assign out_valid = q_valid;
   assign out_rec   = (second_ff || !q_head.has0) ? q_head.r1 : q_head.r0;
   assign out_end   = !both || second_ff;
   assign q_pop     = q_valid && out_ready && out_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else if (q_valid && out_ready) begin
         second_ff <= both && !second_ff;
      end
   end
endmodule
`default_nettype wire

[src/tx_skeleton_stream_parser.sv]
// A byte's results go, as it is transferred, into a four-entry queue between
// parser and emitter. Throughput: one byte per cycle unless the queue is full;
// a byte with two results holds the result port until both are taken in turn.
// Reset: synchronous, active high; clears parse state, queue and registers to
// their defaults (1000, 1000, 10000).
`default_nettype none
module tx_skeleton_stream_parser #(
   parameter int COUNT_LIMIT  = tsp_pkg::COUNT_LIMIT_DEF,
   parameter int SCRIPT_LIMIT = tsp_pkg::SCRIPT_LIMIT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_frame_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_field_kind,
   output logic [63:0]      rsp_field_value,
   output logic [9:0]       rsp_item_index,
   output logic [13:0]      rsp_byte_position,
   output logic [2:0]       rsp_error_code,
   output logic             rsp_run_end,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [10:0] max_in_ff, max_out_ff;
   logic [13:0] max_scr_ff;
   logic [1:0]  reg_sel;
   logic        q_push, q_full, q_ne, q_pop;
   tsp_pkg::entry_type q_in, q_head;
   tsp_pkg::rec_type   rec;

   assign csr_pready = 1'b1;
   assign reg_sel = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         max_in_ff  <= tsp_pkg::MAX_INPUTS_RST;
         max_out_ff <= tsp_pkg::MAX_OUTPUTS_RST;
         max_scr_ff <= tsp_pkg::MAX_SCRIPT_RST;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_sel)
            tsp_pkg::REG_MAX_INPUTS:  max_in_ff  <= csr_pwdata[10:0];
            tsp_pkg::REG_MAX_OUTPUTS: max_out_ff <= csr_pwdata[10:0];
            tsp_pkg::REG_MAX_SCRIPT:  max_scr_ff <= csr_pwdata[13:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         tsp_pkg::REG_MAX_INPUTS:  csr_prdata = {21'd0, max_in_ff};
         tsp_pkg::REG_MAX_OUTPUTS: csr_prdata = {21'd0, max_out_ff};
         tsp_pkg::REG_MAX_SCRIPT:  csr_prdata = {18'd0, max_scr_ff};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   tsp_front #(.COUNT_LIMIT(COUNT_LIMIT), .SCRIPT_LIMIT(SCRIPT_LIMIT)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_byte(req_data_byte), .in_last(req_frame_last),
      .in_ready(req_ready),
      .max_inputs(max_in_ff), .max_outputs(max_out_ff), .max_script_len(max_scr_ff),
      .q_push(q_push), .q_data(q_in), .q_full(q_full)
   );

   tsp_fifo u_fifo (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in),
      .full(q_full), .not_empty(q_ne), .head(q_head), .pop(q_pop)
   );

   tsp_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_ne), .q_head(q_head), .q_pop(q_pop),
      .out_valid(rsp_valid), .out_rec(rec), .out_end(rsp_run_end),
      .out_ready(rsp_ready)
   );

   assign rsp_field_kind    = rec.kind;
   assign rsp_field_value   = rec.value;
   assign rsp_item_index    = rec.index;
   assign rsp_byte_position = rec.pos;
   assign rsp_error_code    = rec.code;
endmodule
`default_nettype wire

[src/tsp_checker.sv]
`default_nettype none
`include "tx_skeleton_stream_parser_defines.svh"
module tsp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  rsp_field_kind,
   input wire logic [63:0] rsp_field_value,
   input wire logic [2:0]  rsp_error_code,
   input wire logic        rsp_run_end,
   input wire logic        csr_pready
);
   `TSP_ASSERT(a_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_field_kind), "result dropped while stalled")
   `TSP_ASSERT(a_err_code, clock, reset, rsp_valid && rsp_field_kind != tsp_pkg::KIND_ERROR |-> rsp_error_code == tsp_pkg::ERR_NONE, "error code on a non-error result")
   `TSP_ASSERT(a_done_end, clock, reset, rsp_valid && rsp_field_kind == tsp_pkg::KIND_DONE |-> rsp_run_end && rsp_field_value == 64'd0, "done not last or nonzero")
   `TSP_ASSERT_ALWAYS(a_pready, clock, csr_pready, "pready low")
endmodule

bind tx_skeleton_stream_parser tsp_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_field_kind(rsp_field_kind), .rsp_field_value(rsp_field_value),
   .rsp_error_code(rsp_error_code), .rsp_run_end(rsp_run_end), .csr_pready(csr_pready)
);
`default_nettype wire
